/* sv/autorange_freq_meter_filter_assert.svh */
// Assertion macros shared by the autorange frequency meter filter RTL
`ifndef AUTORANGE_FREQ_METER_FILTER_ASSERT_SVH
`define AUTORANGE_FREQ_METER_FILTER_ASSERT_SVH

`ifndef ASSERT_OFF
// Clocked check, disabled while reset is asserted
`define AFM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
// Clocked check that also holds during reset
`define AFM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define AFM_ASSERT(lbl, clk, rstn, prop)
`define AFM_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* sv/afm_pkg.sv */
// Shared constants and types of the autorange frequency meter filter
`timescale 1ns / 1ps
`default_nettype none

package afm_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int FRAC_BITS   = 8;

  localparam int FIELD_W = 32;
  localparam int FREQ_W  = 44;
  localparam int THR_W   = 16;
  localparam int REF_W   = 27;
  localparam int NUM_W   = REF_W + FRAC_BITS;
  localparam int SCALE_W = FREQ_W + 4;
  localparam int DCNT_W  = $clog2(NUM_W + 1);

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [0:0] REG_THR = 1'b0;
  localparam logic [0:0] REG_REF = 1'b1;

  localparam logic [THR_W-1:0] THR_RST = 16'd1000;
  localparam logic [REF_W-1:0] REF_RST = 27'd100000000;

  typedef struct packed {
    logic [THR_W-1:0] low_count_threshold;
    logic [REF_W-1:0] ref_clock_hz;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

/* sv/afm_in_if.sv */
// Request channel of the autorange frequency meter filter
`timescale 1ns / 1ps
`default_nettype none

interface afm_in_if;
  import afm_pkg::*;

  logic               valid;
  logic               ready;
  logic               req_type;
  logic               freq_ready;
  logic               period_ready;
  logic [FIELD_W-1:0] gate_count;
  logic [FIELD_W-1:0] period_count;

  modport source (
    output valid, req_type, freq_ready, period_ready, gate_count, period_count,
    input  ready
  );

  modport sink (
    input  valid, req_type, freq_ready, period_ready, gate_count, period_count,
    output ready
  );
endinterface

`default_nettype wire

/* sv/afm_out_if.sv */
// Result channel of the autorange frequency meter filter
`timescale 1ns / 1ps
`default_nettype none

interface afm_out_if;
  import afm_pkg::*;

  logic              valid;
  logic              ready;
  logic [FREQ_W-1:0] freq_value;
  logic              freq_valid;
  logic              period_mode;

  modport source (
    output valid, freq_value, freq_valid, period_mode,
    input  ready
  );

  modport sink (
    input  valid, freq_value, freq_valid, period_mode,
    output ready
  );
endinterface

`default_nettype wire

/* sv/autorange_freq_meter_filter.sv */
// Top level of the autorange frequency meter filter
//
//  channel | direction | handshake          | payload
//  in_ch   | in        | valid / ready      | req_type, freq_ready, period_ready,
//          |           |                    | gate_count, period_count
//  out_ch  | out       | valid / ready      | freq_value, freq_valid, period_mode
//  apb     | in        | psel, penable      | paddr, pwrite, pwdata, prdata
//
// A clear request goes straight to the result; ignored flags or a bare switch to period
// mode add no candidate. A gate reading or a zero period count is scaled and checked for
// tolerance; a period reading first runs the restoring divider (one quotient bit per
// cycle over 27 + FRAC_BITS bits). in_ch.ready is high only between requests; the result
// register takes a finished result while out_ch stalls, and the next one holds the
// sequencer until it is free. Reset is asynchronous, active low, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

`include "autorange_freq_meter_filter_assert.svh"

module autorange_freq_meter_filter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  afm_in_if.sink                      in_ch,
  afm_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [afm_pkg::PADDR_W-1:0] paddr,
  input  logic [afm_pkg::PDATA_W-1:0] pwdata,
  output logic [afm_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import afm_pkg::*;

  cfg_t cfg;

  afm_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  afm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  `AFM_ASSERT(a_busy_after_req, clk_i, rst_ni, in_ch.valid && in_ch.ready |=> !in_ch.ready)
  `AFM_ASSERT(a_invalid_is_zero, clk_i, rst_ni, out_ch.valid && !out_ch.freq_valid |-> out_ch.freq_value == '0)
  `AFM_ASSERT_ALWAYS(a_no_result_in_reset, clk_i, !rst_ni |-> !out_ch.valid)

endmodule

`default_nettype wire

/* sv/afm_apb_regs.sv */
// APB configuration registers: low count threshold and reference clock
`timescale 1ns / 1ps
`default_nettype none

module afm_apb_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [afm_pkg::PADDR_W-1:0]  paddr,
  input  logic [afm_pkg::PDATA_W-1:0]  pwdata,
  output logic [afm_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output afm_pkg::cfg_t                cfg_o
);
  import afm_pkg::*;

  logic [THR_W-1:0] thr_q;
  logic [REF_W-1:0] ref_q;
  logic             wr_en;
  logic [0:0]       reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RST;
      ref_q <= REF_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_THR: thr_q <= pwdata[THR_W-1:0];
        REG_REF: ref_q <= pwdata[REF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_THR: prdata = PDATA_W'(thr_q);
      REG_REF: prdata = PDATA_W'(ref_q);
      default: prdata = '0;
    endcase
  end

  assign cfg_o.low_count_threshold = thr_q;
  assign cfg_o.ref_clock_hz        = ref_q;

endmodule

`default_nettype wire

/* sv/afm_divider.sv */
// Restoring shift-subtract divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module afm_divider (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [afm_pkg::NUM_W-1:0]       num_i,
  input  logic [afm_pkg::COUNT_WIDTH-1:0] den_i,
  output afm_pkg::div_stat_t              stat_o,
  output logic [afm_pkg::NUM_W-1:0]       quot_o
);
  import afm_pkg::*;

  logic                   busy_q;
  logic                   done_q;
  logic [DCNT_W-1:0]      cnt_q;
  logic [NUM_W-1:0]       num_q;
  logic [COUNT_WIDTH-1:0] rem_q;
  logic [COUNT_WIDTH-1:0] den_q;
  logic [COUNT_WIDTH:0]   rem_sh;
  logic [COUNT_WIDTH+1:0] diff;
  logic                   ge;

  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_q};
  assign ge     = ~diff[COUNT_WIDTH+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      num_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DCNT_W'(NUM_W);
        num_q  <= num_i;
        rem_q  <= '0;
        den_q  <= den_i;
      end else if (busy_q) begin
        // shift the quotient bit in where the dividend bit leaves
        num_q <= {num_q[NUM_W-2:0], ge};
        rem_q <= ge ? diff[COUNT_WIDTH-1:0] : rem_sh[COUNT_WIDTH-1:0];
        cnt_q <= cnt_q - DCNT_W'(1);
        if (cnt_q == DCNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = num_q;

endmodule

`default_nettype wire

/* sv/afm_core.sv */
// Sequencer: mode switching, candidate forming, tolerance check, result register
`timescale 1ns / 1ps
`default_nettype none

module afm_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  afm_pkg::cfg_t cfg_i,
  afm_in_if.sink        in_ch,
  afm_out_if.source     out_ch
);
  import afm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GATE,
    S_PSTEP,
    S_DIV,
    S_SCALE,
    S_CHK_LO,
    S_CHK_HI,
    S_DONE
  } state_e;

  state_e                 state_q;
  logic                   f_rdy_q;
  logic                   p_rdy_q;
  logic [COUNT_WIDTH-1:0] gate_q;
  logic [COUNT_WIDTH-1:0] period_q;
  logic                   use_period_q;
  logic [FREQ_W-1:0]      prev_q;
  logic [FREQ_W-1:0]      held_q;
  logic                   held_valid_q;
  logic [FREQ_W-1:0]      cand_q;
  logic [SCALE_W-1:0]     scaled_q;
  logic                   lo_fail_q;
  logic                   phase_q;
  logic                   div_start_q;
  logic                   out_valid_q;
  logic [FREQ_W-1:0]      out_freq_q;
  logic                   out_fvalid_q;
  logic                   out_mode_q;

  logic [COUNT_WIDTH+3:0] gate10;
  logic [63:0]            gate_wide;
  logic [FREQ_W-1:0]      gate_cand;
  logic [SCALE_W-1:0]     prev9;
  logic [SCALE_W-1:0]     prev11;
  logic                   hi_fail;
  div_stat_t              div_stat;
  logic [NUM_W-1:0]       div_quot;
  logic                   out_take;

  assign gate10    = (COUNT_WIDTH+4)'({gate_q, 3'b000}) + (COUNT_WIDTH+4)'({gate_q, 1'b0});
  assign gate_wide = 64'(gate10) << FRAC_BITS;
  assign gate_cand = (|gate_wide[63:FREQ_W]) ? '1 : gate_wide[FREQ_W-1:0];

  assign prev9   = SCALE_W'({prev_q, 3'b000}) + SCALE_W'(prev_q);
  assign prev11  = prev9 + SCALE_W'({prev_q, 1'b0});
  assign hi_fail = scaled_q > prev11;

  assign out_take = out_valid_q & out_ch.ready;

  afm_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (NUM_W'(cfg_i.ref_clock_hz) << FRAC_BITS),
    .den_i   (period_q),
    .stat_o  (div_stat),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      f_rdy_q      <= 1'b0;
      p_rdy_q      <= 1'b0;
      gate_q       <= '0;
      period_q     <= '0;
      use_period_q <= 1'b0;
      prev_q       <= '0;
      held_q       <= '0;
      held_valid_q <= 1'b0;
      cand_q       <= '0;
      scaled_q     <= '0;
      lo_fail_q    <= 1'b0;
      phase_q      <= 1'b0;
      div_start_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      out_freq_q   <= '0;
      out_fvalid_q <= 1'b0;
      out_mode_q   <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      if (out_take) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_ch.valid) begin
            f_rdy_q  <= in_ch.freq_ready;
            p_rdy_q  <= in_ch.period_ready;
            gate_q   <= in_ch.gate_count[COUNT_WIDTH-1:0];
            period_q <= in_ch.period_count[COUNT_WIDTH-1:0];
            if (in_ch.req_type) begin
              // clear request: drop the held value, keep mode and history
              held_q       <= '0;
              held_valid_q <= 1'b0;
              state_q      <= S_DONE;
            end else begin
              state_q <= S_GATE;
            end
          end
        end
        S_GATE: begin
          state_q <= S_PSTEP;
          if (f_rdy_q && !use_period_q) begin
            if (gate_q < COUNT_WIDTH'(cfg_i.low_count_threshold)) begin
              use_period_q <= 1'b1;
            end else begin
              cand_q  <= gate_cand;
              phase_q <= 1'b0;
              state_q <= S_SCALE;
            end
          end
        end
        S_PSTEP: begin
          if (p_rdy_q && use_period_q) begin
            use_period_q <= 1'b0;
            phase_q      <= 1'b1;
            if (period_q == '0) begin
              cand_q  <= '0;
              state_q <= S_SCALE;
            end else begin
              div_start_q <= 1'b1;
              state_q     <= S_DIV;
            end
          end else begin
            state_q <= S_DONE;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            cand_q  <= FREQ_W'(div_quot);
            state_q <= S_SCALE;
          end
        end
        S_SCALE: begin
          scaled_q <= SCALE_W'({cand_q, 3'b000}) + SCALE_W'({cand_q, 1'b0});
          state_q  <= S_CHK_LO;
        end
        S_CHK_LO: begin
          lo_fail_q <= scaled_q < prev9;
          state_q   <= S_CHK_HI;
        end
        S_CHK_HI: begin
          if (lo_fail_q || hi_fail) begin
            held_q       <= '0;
            held_valid_q <= 1'b0;
          end else begin
            held_q       <= cand_q;
            held_valid_q <= 1'b1;
          end
          prev_q  <= cand_q;
          state_q <= phase_q ? S_DONE : S_PSTEP;
        end
        S_DONE: begin
          // hold until the result register is free
          if (!out_valid_q || out_ch.ready) begin
            out_valid_q  <= 1'b1;
            out_freq_q   <= held_q;
            out_fvalid_q <= held_valid_q;
            out_mode_q   <= use_period_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready        = (state_q == S_IDLE);
  assign out_ch.valid       = out_valid_q;
  assign out_ch.freq_value  = out_freq_q;
  assign out_ch.freq_valid  = out_fvalid_q;
  assign out_ch.period_mode = out_mode_q;

endmodule

`default_nettype wire
